>>> design/direct_mapped_writeback_cache_defines.svh
// Assertion macros used by the cache top level.
// No dependencies; included by the top level.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define DMC_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset.
`define DMC_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> design/dmc_pkg.sv
// Types and constants shared by the cache front end, back end and top level.
// No dependencies.
package dmc_pkg;
  localparam int unsigned REG_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ADDR_W = 18;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_INVAL = 2'd3
  } req_e;

  localparam logic [CFG_IDX_W-1:0] CFG_DRAM_RD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAM_WR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_RD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WR   = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [31:0]       write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic [31:0] elapsed_time;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] mem_rd_lat;
    logic [REG_W-1:0] mem_wr_lat;
    logic [REG_W-1:0] hit_rd_lat;
    logic [REG_W-1:0] hit_wr_lat;
  } cfg_t;
endpackage

>>> design/direct_mapped_writeback_cache.sv
// Top level of the direct-mapped write-back cache with its backing memory.
// Depends on dmc_pkg, dmc_front, dmc_back and the assertion macro header.
// The back end handles one item at a time. A hit passes through its states
// in order (take from the queue, look up, access the word, present the result).
// A clear of the time total skips the word access. A miss first writes the old
// line back if it is dirty and then fills the line, one word moving per cycle.
// Invalidate-all walks every line, one per cycle. A stalled result holds the
// back end. Right after reset the backing memory is cleared to zero one word
// per cycle; items queue up meanwhile and then see the input stall.
// A two-entry queue in front lets new items be accepted while one is worked on.
// Results come one per item, in order.
`include "direct_mapped_writeback_cache_defines.svh"
module direct_mapped_writeback_cache #(
  parameter int unsigned LINES       = 256,
  parameter int unsigned BLOCK_WORDS = 16,
  parameter int unsigned MEM_WORDS   = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dmc_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dmc_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmc_pkg::REG_W-1:0]        cfg_wdata
);
  dmc_pkg::cfg_t     cfg_r;
  dmc_pkg::in_item_t q_data;
  logic              q_valid, q_pop;

  // Configuration registers; the index space is exactly four.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mem_rd_lat <= 10'd100;
      cfg_r.mem_wr_lat <= 10'd50;
      cfg_r.hit_rd_lat <= 10'd1;
      cfg_r.hit_wr_lat <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmc_pkg::CFG_DRAM_RD: cfg_r.mem_rd_lat <= cfg_wdata;
        dmc_pkg::CFG_DRAM_WR: cfg_r.mem_wr_lat <= cfg_wdata;
        dmc_pkg::CFG_L1_RD:   cfg_r.hit_rd_lat <= cfg_wdata;
        dmc_pkg::CFG_L1_WR:   cfg_r.hit_wr_lat <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dmc_front #(.DEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  dmc_back #(.LINES(LINES), .BLOCK_WORDS(BLOCK_WORDS), .MEM_WORDS(MEM_WORDS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );

  // A pop only happens with an item queued.
  `DMC_ASSERT_IMP(a_pop_has_item, clk, rst_n, q_pop, q_valid, "pop of empty queue")
  // A result is never shown in the cycle right after an item is taken.
  `DMC_ASSERT_NEXT(a_pop_not_out, clk, rst_n, q_pop, !out_valid, "result too early")
endmodule

>>> design/dmc_front.sv
// Front end: accepts request items into a short queue for the back end.
// Depends on dmc_pkg.
module dmc_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dmc_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output dmc_pkg::in_item_t q_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dmc_pkg::in_item_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push;

  assign in_stall = (cnt_r == (PW+1)'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

>>> design/dmc_back.sv
// Back end: tag lookup, writeback, fill, word access, invalidate-all, memory clear and time totals.
// Depends on dmc_pkg.
module dmc_back #(
  parameter int unsigned LINES       = 256,
  parameter int unsigned BLOCK_WORDS = 16,
  parameter int unsigned MEM_WORDS   = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dmc_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  dmc_pkg::in_item_t  q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dmc_pkg::out_item_t out_data
);
  localparam int unsigned WW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int unsigned LW = $clog2(LINES);
  localparam int unsigned MW = $clog2(MEM_WORDS);
  localparam int unsigned CW = $clog2(LINES * BLOCK_WORDS);
  localparam int unsigned WADDR_W = dmc_pkg::ADDR_W - 2;
  localparam int unsigned TW = (WADDR_W > WW + LW) ? WADDR_W - WW - LW : 1;
  localparam int unsigned KW = $clog2(BLOCK_WORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_WB, S_FILL, S_ACC, S_INV, S_OUT, S_CLR
  } state_t;

  state_t state_r;
  logic [LINES-1:0] valid_r, dirty_r;
  logic [TW-1:0]    tag_r [LINES];
  logic [31:0]      cdata [LINES * BLOCK_WORDS];
  logic [31:0]      bmem  [MEM_WORDS];

  dmc_pkg::in_item_t  req_r;
  dmc_pkg::out_item_t out_r;
  logic [31:0] time_r;
  logic [KW-1:0] k_r;
  logic [LW-1:0] inv_r;
  logic [MW-1:0] clr_r;
  logic [31:0] crd_r, brd_r;
  logic        rd_ok_r;
  logic [TW-1:0] old_tag_r;
  logic        look_valid_r, look_dirty_r;
  logic [TW-1:0] look_tag_r;

  logic [WADDR_W-1:0] waddr, q_waddr;
  logic [WW-1:0] word;
  logic [LW-1:0] line, q_line;
  logic [TW-1:0] tag;
  logic [WW-1:0] kk, kprev;
  logic [CW-1:0] cbase;
  logic [63:0]   wb_lin, fl_lin;
  logic [MW-1:0] wb_addr, fl_addr;

  assign waddr = req_r.address[dmc_pkg::ADDR_W-1:2];
  assign word  = (BLOCK_WORDS > 1) ? WW'(waddr % BLOCK_WORDS) : '0;
  assign line  = LW'((waddr / BLOCK_WORDS) % LINES);
  assign tag   = TW'(waddr / (BLOCK_WORDS * LINES));
  assign q_waddr = q_data.address[dmc_pkg::ADDR_W-1:2];
  assign q_line  = LW'((q_waddr / BLOCK_WORDS) % LINES);
  assign kk    = WW'(k_r);
  assign kprev = WW'(k_r - 1'b1);
  assign cbase = CW'(line) * CW'(BLOCK_WORDS);
  assign wb_lin = ((64'(old_tag_r) * LINES + 64'(line)) * BLOCK_WORDS) + 64'(kprev);
  assign fl_lin = ((64'(tag) * LINES + 64'(line)) * BLOCK_WORDS) + 64'(kk);
  assign wb_addr = MW'(wb_lin % MEM_WORDS);
  assign fl_addr = MW'(fl_lin % MEM_WORDS);

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  // Memory ports: word k is read while word k-1, held in a register from the
  // previous read, is written. After reset the backing memory is cleared one word per cycle.
  always_ff @(posedge clk) begin
    crd_r <= cdata[cbase + CW'(kk)];
    brd_r <= bmem[fl_addr];
    if (state_r == S_CLR) begin
      bmem[clr_r] <= '0;
    end else if (state_r == S_WB && rd_ok_r) begin
      bmem[wb_addr] <= crd_r;
    end
    if (state_r == S_FILL && rd_ok_r) begin
      cdata[cbase + CW'(kprev)] <= brd_r;
    end
    if (state_r == S_ACC && req_r.req_type == dmc_pkg::REQ_WRITE) begin
      cdata[cbase + CW'(word)] <= req_r.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) begin
      req_r <= q_data;
    end
    if (!rst_n) begin
      state_r <= S_CLR;
      valid_r <= '0;
      dirty_r <= '0;
      time_r  <= '0;
      k_r     <= '0;
      inv_r   <= '0;
      clr_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == MW'(MEM_WORDS-1)) state_r <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          // Line state is read here so the lookup uses registered values.
          look_valid_r <= valid_r[q_line];
          look_dirty_r <= dirty_r[q_line];
          look_tag_r   <= tag_r[q_line];
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          k_r <= '0;
          rd_ok_r <= 1'b0;
          out_r.read_data <= '0;
          out_r.hit <= 1'b0;
          priority case (req_r.req_type)
            dmc_pkg::REQ_CLEAR: begin
              time_r <= '0;
              out_r.elapsed_time <= '0;
              state_r <= S_OUT;
            end
            dmc_pkg::REQ_INVAL: begin
              inv_r <= '0;
              state_r <= S_INV;
            end
            default: begin
              if (look_valid_r && look_tag_r == tag) begin
                out_r.hit <= 1'b1;
                state_r <= S_ACC;
              end else begin
                old_tag_r <= look_tag_r;
                time_r <= time_r + 32'(cfg.mem_rd_lat);
                if (look_valid_r && look_dirty_r) begin
                  state_r <= S_WB;
                end else begin
                  state_r <= S_FILL;
                end
              end
            end
          endcase
        end
        S_WB: begin
          // Read word k and write the previous one, held in the read register.
          if (k_r == KW'(BLOCK_WORDS)) begin
            time_r <= time_r + 32'(cfg.mem_wr_lat);
            k_r <= '0;
            rd_ok_r <= 1'b0;
            state_r <= S_FILL;
          end else begin
            rd_ok_r <= 1'b1;
            k_r <= k_r + 1'b1;
          end
        end
        S_FILL: begin
          if (k_r == KW'(BLOCK_WORDS)) begin
            valid_r[line] <= 1'b1;
            dirty_r[line] <= 1'b0;
            tag_r[line] <= tag;
            state_r <= S_ACC;
          end else begin
            rd_ok_r <= 1'b1;
            k_r <= k_r + 1'b1;
          end
        end
        S_ACC: begin
          if (req_r.req_type == dmc_pkg::REQ_READ) begin
            out_r.read_data <= cdata[cbase + CW'(word)];
            time_r <= time_r + 32'(cfg.hit_rd_lat);
            out_r.elapsed_time <= time_r + 32'(cfg.hit_rd_lat);
          end else begin
            dirty_r[line] <= 1'b1;
            time_r <= time_r + 32'(cfg.hit_wr_lat);
            out_r.elapsed_time <= time_r + 32'(cfg.hit_wr_lat);
          end
          state_r <= S_OUT;
        end
        S_INV: begin
          valid_r[inv_r] <= 1'b0;
          dirty_r[inv_r] <= 1'b0;
          tag_r[inv_r] <= '0;
          inv_r <= inv_r + 1'b1;
          if (inv_r == LW'(LINES-1)) begin
            out_r.elapsed_time <= time_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> tb/sv/tb_direct_mapped_writeback_cache.sv
`timescale 1ns / 100ps
// Self-checking testbench for the direct-mapped write-back cache.
// Depends on dmc_pkg and the direct_mapped_writeback_cache top level.

// Tracks the cache and backing memory contents and the running access time,
// and checks every returned item against the predicted response.
class dmc_scoreboard;
  bit [dmc_pkg::REG_W-1:0] dram_rd_lat;
  bit [dmc_pkg::REG_W-1:0] dram_wr_lat;
  bit [dmc_pkg::REG_W-1:0] l1_rd_lat;
  bit [dmc_pkg::REG_W-1:0] l1_wr_lat;
  bit             line_present[256];
  bit             line_modified[256];
  bit [3:0]       line_tag_of[256];
  bit [31:0]      cached_word[4096];
  bit [31:0]      dram_word[65536];
  bit [31:0]      access_time;
  dmc_pkg::out_item_t expected_resp[$];
  int             errors;

  function new();
    dram_rd_lat = 100;
    dram_wr_lat = 50;
    l1_rd_lat   = 1;
    l1_wr_lat   = 1;
    access_time = 0;
    errors      = 0;
    foreach (line_present[i]) begin
      line_present[i]  = 0;
      line_modified[i] = 0;
      line_tag_of[i]   = 0;
    end
    foreach (dram_word[i]) dram_word[i] = 0;
    foreach (cached_word[i]) cached_word[i] = 0;
  endfunction

  function void write_latency(logic [dmc_pkg::CFG_IDX_W-1:0] idx,
                              bit [dmc_pkg::REG_W-1:0] val);
    case (idx)
      dmc_pkg::CFG_DRAM_RD: dram_rd_lat = val;
      dmc_pkg::CFG_DRAM_WR: dram_wr_lat = val;
      dmc_pkg::CFG_L1_RD:   l1_rd_lat   = val;
      dmc_pkg::CFG_L1_WR:   l1_wr_lat   = val;
      default: ;
    endcase
  endfunction

  // Applies one accepted request to the shadow state and queues its response.
  function void note_request(dmc_pkg::in_item_t req);
    dmc_pkg::out_item_t resp;
    bit [7:0]  line;
    bit [3:0]  tag;
    bit [3:0]  word;
    resp = '0;
    line = req.address[13:6];
    tag  = req.address[17:14];
    word = req.address[5:2];
    case (dmc_pkg::req_e'(req.req_type))
      dmc_pkg::REQ_CLEAR: access_time = 0;
      dmc_pkg::REQ_INVAL: begin
        // Dirty lines are simply dropped; nothing goes back to memory.
        foreach (line_present[i]) begin
          line_present[i]  = 0;
          line_modified[i] = 0;
          line_tag_of[i]   = 0;
        end
      end
      default: begin
        if (line_present[line] && line_tag_of[line] == tag) begin
          resp.hit = 1;
        end else begin
          access_time += dram_rd_lat;
          if (line_present[line] && line_modified[line]) begin
            for (int k = 0; k < 16; k++)
              dram_word[{line_tag_of[line], line, k[3:0]}] = cached_word[{line, k[3:0]}];
            access_time += dram_wr_lat;
          end
          for (int k = 0; k < 16; k++)
            cached_word[{line, k[3:0]}] = dram_word[{tag, line, k[3:0]}];
          line_present[line]  = 1;
          line_tag_of[line]   = tag;
          line_modified[line] = 0;
        end
        if (dmc_pkg::req_e'(req.req_type) == dmc_pkg::REQ_READ) begin
          resp.read_data = cached_word[{line, word}];
          access_time += l1_rd_lat;
        end else begin
          cached_word[{line, word}] = req.write_data;
          access_time += l1_wr_lat;
          line_modified[line] = 1;
        end
      end
    endcase
    resp.elapsed_time = access_time;
    expected_resp.push_back(resp);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(dmc_pkg::out_item_t got);
    dmc_pkg::out_item_t want;
    if (expected_resp.size() == 0) begin
      report("response with no request outstanding");
    end else begin
      want = expected_resp.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
      if (got.hit !== want.hit)
        report($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.elapsed_time !== want.elapsed_time)
        report($sformatf("elapsed_time got %h want %h",
                         got.elapsed_time, want.elapsed_time));
    end
  endtask
endclass

module tb_direct_mapped_writeback_cache;
  // The block clears its backing memory after reset, while no result comes out and
  // the input soon stalls; the limit sits well above the length of that clear.
  localparam int STALL_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 400;
  localparam int AW = dmc_pkg::ADDR_W;
  localparam int RW = dmc_pkg::REG_W;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dmc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dmc_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [RW-1:0]      cfg_wdata;

  dmc_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  direct_mapped_writeback_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // The receiver decides each cycle, on the falling edge, whether to stall.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Handshakes are sampled on the rising edge. A long run with no item moving
  // on either channel means the block has hung.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one item and holds it until the block takes it. Idle cycles are
  // inserted before valid rises, so valid never reacts to stall.
  task send_request(dmc_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task send_op(dmc_pkg::req_e op, logic [AW-1:0] addr, logic [31:0] wdata);
    dmc_pkg::in_item_t req;
    req.req_type   = op;
    req.address    = addr;
    req.write_data = wdata;
    send_request(req);
  endtask

  // Waits for every outstanding response, by which time any invalidate walk or
  // writeback is done, then idles before the block is touched again.
  task drain;
    in_valid <= 0;
    while (sb.expected_resp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task set_latency(logic [dmc_pkg::CFG_IDX_W-1:0] idx, logic [RW-1:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_latency(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Most accesses land on a few lines and tags, so hits, dirty evictions and
  // read-backs of written data are common; the rest use any address.
  function automatic dmc_pkg::in_item_t random_request();
    dmc_pkg::in_item_t req;
    int       pick;
    logic [7:0] line_pool[4];
    line_pool = '{8'h00, 8'h01, 8'hFF, 8'h5A};
    pick = $urandom_range(99);
    if (pick < 46)      req.req_type = dmc_pkg::REQ_READ;
    else if (pick < 94) req.req_type = dmc_pkg::REQ_WRITE;
    else if (pick < 98) req.req_type = dmc_pkg::REQ_CLEAR;
    else                req.req_type = dmc_pkg::REQ_INVAL;
    if ($urandom_range(99) < 75)
      req.address = {4'($urandom_range(3) * 5), line_pool[$urandom_range(3)],
                     4'($urandom), 2'($urandom)};
    else
      req.address = AW'($urandom);
    req.write_data = $urandom;
    return req;
  endfunction

  initial begin
    sb = new();
    rst_n         = 0;
    in_valid      = 0;
    in_data       = '0;
    cfg_we        = 0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    send_idle_pct = 32;
    recv_idle_pct = 76;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part, with the reset latencies: cold misses, a hit through an
    // unaligned address, dirty evictions and read-back from memory, the top of
    // the address range, a read that must keep the line dirty, an invalidate
    // that drops dirty data, and a clear of the time total.
    send_op(dmc_pkg::REQ_WRITE, 18'h00000, 32'hFFFF_FFFF);
    send_op(dmc_pkg::REQ_READ,  18'h00003, 32'h0);
    send_op(dmc_pkg::REQ_WRITE, 18'h00004, 32'h0000_0000);
    send_op(dmc_pkg::REQ_READ,  18'h00004, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h04000, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h00000, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h3FFFF, 32'h0);
    send_op(dmc_pkg::REQ_WRITE, 18'h3FFFC, 32'hA5A5_A5A5);
    send_op(dmc_pkg::REQ_READ,  18'h3FFFC, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h03FC0, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h3FFFC, 32'h0);
    send_op(dmc_pkg::REQ_WRITE, 18'h01000, 32'h1234_5678);
    send_op(dmc_pkg::REQ_INVAL, 18'h3FFFF, 32'hFFFF_FFFF);
    send_op(dmc_pkg::REQ_READ,  18'h01000, 32'h0);
    send_op(dmc_pkg::REQ_WRITE, 18'h2AAA8, 32'h5A5A_5A5A);
    send_op(dmc_pkg::REQ_CLEAR, 18'h15554, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h2AAA8, 32'h0);
    send_op(dmc_pkg::REQ_READ,  18'h00000, 32'h0);

    // Three random phases, each under its own latency setting and idling mix.
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          set_latency(dmc_pkg::CFG_DRAM_RD, 10'h3FF);
          set_latency(dmc_pkg::CFG_DRAM_WR, 10'h3FF);
          set_latency(dmc_pkg::CFG_L1_RD,   10'h3FF);
          set_latency(dmc_pkg::CFG_L1_WR,   10'h3FF);
          send_idle_pct = 32;
          recv_idle_pct = 76;
        end
        1: begin
          set_latency(dmc_pkg::CFG_DRAM_RD, 10'h000);
          set_latency(dmc_pkg::CFG_DRAM_WR, 10'h000);
          set_latency(dmc_pkg::CFG_L1_RD,   10'h000);
          set_latency(dmc_pkg::CFG_L1_WR,   10'h000);
          send_idle_pct = 76;
          recv_idle_pct = 32;
        end
        default: begin
          set_latency(dmc_pkg::CFG_DRAM_RD, RW'($urandom));
          set_latency(dmc_pkg::CFG_DRAM_WR, RW'($urandom));
          set_latency(dmc_pkg::CFG_L1_RD,   RW'($urandom));
          set_latency(dmc_pkg::CFG_L1_WR,   RW'($urandom));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (330) send_request(random_request());
    end

    drain();
    if (sb.errors == 0 && sb.expected_resp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> direct_mapped_writeback_cache.f
+incdir+design
design/dmc_pkg.sv
design/dmc_front.sv
design/dmc_back.sv
design/direct_mapped_writeback_cache.sv
tb/sv/tb_direct_mapped_writeback_cache.sv
